// ===== src/srmm_pkg.sv =====
// Shared types, field widths, codes and a helper function for the sparse-table
// range min/max engine. No dependencies; the two interfaces, the top level and the testbench use it.
`default_nettype none

package srmm_pkg;

	// Fixed field widths of the channel payloads.
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 10;
	localparam int LEN_W    = INDEX_W + 1;
	localparam int STATUS_W = 2;
	localparam int LOG_W    = 5;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LOADED   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_Q_RD,
		ST_Q_CMP,
		ST_B_CHK,
		ST_B_RD,
		ST_B_WR
	} state_t;

	// Position of the highest set bit of a range length (floor of log2).
	function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] len);
		logic [LOG_W-1:0] k;
		k = '0;
		for (int i = 0; i < LEN_W; i++) begin
			if (len[i]) begin
				k = LOG_W'(i);
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== src/srmm_in_if.sv =====
// Input channel interface of the range min/max engine: valid/ready plus the
// load and query payload fields. Depends on srmm_pkg for field widths.
`default_nettype none

interface srmm_in_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic signed [srmm_pkg::VALUE_W-1:0] value;
	logic                               last_load;
	logic [srmm_pkg::INDEX_W-1:0]       range_low;
	logic [srmm_pkg::INDEX_W-1:0]       range_high;

	modport source (
		output valid, kind, value, last_load, range_low, range_high,
		input  ready
	);
	modport sink (
		input  valid, kind, value, last_load, range_low, range_high,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/srmm_out_if.sv =====
// Result channel interface of the range min/max engine: valid/ready plus the
// minimum, maximum and status fields. Depends on srmm_pkg for field widths.
`default_nettype none

interface srmm_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [srmm_pkg::VALUE_W-1:0]  range_min;
	logic signed [srmm_pkg::VALUE_W-1:0]  range_max;
	logic [srmm_pkg::STATUS_W-1:0]       status;

	modport source (
		output valid, range_min, range_max, status,
		input  ready
	);
	modport sink (
		input  valid, range_min, range_max, status,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/srmm_tables.sv =====
// Min and max doubling tables: one write port and two registered read ports,
// addressed by level and position. Uses no package items.
`default_nettype none

module srmm_tables #(
	parameter int CAPACITY = 1024,
	parameter int LEVELS   = 11,
	parameter int W        = 32
) (
	input  wire                         clk,
	input  wire                         wr_en,
	input  wire  [$clog2(LEVELS)-1:0]   wr_lvl,
	input  wire  [$clog2(CAPACITY)-1:0] wr_pos,
	input  wire  [W-1:0]                wr_min,
	input  wire  [W-1:0]                wr_max,
	input  wire                         rd_en,
	input  wire  [$clog2(LEVELS)-1:0]   rd0_lvl,
	input  wire  [$clog2(CAPACITY)-1:0] rd0_pos,
	input  wire  [$clog2(LEVELS)-1:0]   rd1_lvl,
	input  wire  [$clog2(CAPACITY)-1:0] rd1_pos,
	output logic [W-1:0]                rd0_min,
	output logic [W-1:0]                rd0_max,
	output logic [W-1:0]                rd1_min,
	output logic [W-1:0]                rd1_max
);

	logic [W-1:0] min_mem [LEVELS][CAPACITY];
	logic [W-1:0] max_mem [LEVELS][CAPACITY];

	// Single write port shared by loads and the table build.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			min_mem[wr_lvl][wr_pos] <= wr_min;
			max_mem[wr_lvl][wr_pos] <= wr_max;
		end
	end

	// Two read ports with registered data; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd0_min <= min_mem[rd0_lvl][rd0_pos];
			rd0_max <= max_mem[rd0_lvl][rd0_pos];
			rd1_min <= min_mem[rd1_lvl][rd1_pos];
			rd1_max <= max_mem[rd1_lvl][rd1_pos];
		end
	end

endmodule

`default_nettype wire

// ===== src/srmm_cmp.sv =====
// Shared signed compare unit: the minimum of one pair and the maximum of another.
// Used for both the table build and the query answer. Uses no package items.
`default_nettype none

module srmm_cmp #(
	parameter int W = 32
) (
	input  wire  [W-1:0] a_min,
	input  wire  [W-1:0] b_min,
	input  wire  [W-1:0] a_max,
	input  wire  [W-1:0] b_max,
	output logic [W-1:0] res_min,
	output logic [W-1:0] res_max
);

	// On a tie either operand gives the same value.
	always_comb begin
		res_min = ($signed(b_min) < $signed(a_min)) ? b_min : a_min;
		res_max = ($signed(a_max) < $signed(b_max)) ? b_max : a_max;
	end

endmodule

`default_nettype wire

// ===== src/sparse_table_range_min_max.sv =====
// Top level of the sparse-table range min/max engine: sequencer, item and result
// registers. Depends on srmm_pkg, srmm_in_if, srmm_out_if, srmm_tables, srmm_cmp.
//
// Use: items arrive on req, one result per item leaves on rsp. A load (kind 0)
// appends value at the next position and answers status 1, or 3 when the set is
// full and the value is dropped. A load flagged last_load ends the set and the
// engine then builds both doubling tables before it takes another item. A query
// (kind 1) answers the min and max over range_low..range_high with status 0, or
// status 2 with zero values for an inverted or out-of-range request or when no
// set is complete. A load after a complete set starts a new set at position 0.
// Sequence: a load is written and answered in the execute state; a valid query is
// decoded and its level selected, then both windows are read from the tables and
// compared; a rejected query is answered at decode. The build after a last load
// runs level by level through the single pair of table read ports and the one
// shared compare unit, which handle one entry at a time, writing each entry
// before the next one is read.
// The result register lets a result wait while the next item is decoded; the
// engine holds in its current state while rsp is stalled and a new result is due.
// Reset clears the loaded count and the ready flag; table contents are not cleared.
`default_nettype none

module sparse_table_range_min_max #(
	parameter int CAPACITY   = 1024,
	parameter int LEVELS     = 11,
	parameter int VALUE_BITS = 32
) (
	input wire          clk,
	input wire          arst_n,
	srmm_in_if.sink     req,
	srmm_out_if.source  rsp
);

	localparam int SW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = $clog2(LEVELS);
	localparam int LW = $clog2(LEVELS + 1);
	localparam int VW = srmm_pkg::VALUE_W;
	localparam int IW = srmm_pkg::INDEX_W;
	localparam int NW = srmm_pkg::LEN_W;

	srmm_pkg::state_t state_q, state_d;

	// Item register.
	logic          kind_q;
	logic [SW-1:0] value_q;
	logic          last_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;

	// Set and build state.
	logic [CW-1:0] count_q;
	logic          table_ready_q;
	logic [LW-1:0] lvl_q;
	logic [AW-1:0] idx_q;
	logic [KW-1:0] k_q;

	// Result register.
	logic                         out_valid_q;
	logic [VW-1:0]                range_min_q;
	logic [VW-1:0]                range_max_q;
	logic [srmm_pkg::STATUS_W-1:0] status_q;

	// Table ports and compare unit.
	logic          wr_en;
	logic [KW-1:0] wr_lvl;
	logic [AW-1:0] wr_pos;
	logic [SW-1:0] wr_min;
	logic [SW-1:0] wr_max;
	logic          rd_en;
	logic [KW-1:0] rd0_lvl;
	logic [AW-1:0] rd0_pos;
	logic [KW-1:0] rd1_lvl;
	logic [AW-1:0] rd1_pos;
	logic [SW-1:0] rd0_min;
	logic [SW-1:0] rd0_max;
	logic [SW-1:0] rd1_min;
	logic [SW-1:0] rd1_max;
	logic [SW-1:0] cmp_min;
	logic [SW-1:0] cmp_max;

	// Sequencer strobes.
	logic                          in_xfer;
	logic                          slot_free;
	logic                          emit;
	logic [srmm_pkg::STATUS_W-1:0] emit_status;
	logic                          load_commit;
	logic                          k_load;
	logic                          build_start;
	logic                          lvl_inc;
	logic                          idx_clr;
	logic                          idx_inc;
	logic                          set_ready;

	// Decode helpers.
	logic [CW-1:0]              eff_count;
	logic                       ovf;
	logic                       bad_query;
	logic [NW-1:0]              len;
	logic [srmm_pkg::LOG_W-1:0] k_raw;
	logic [KW-1:0]              k_lim;
	logic [NW-1:0]              j2;
	logic                       lvl_ok;
	logic                       idx_ok;

	srmm_tables #(
		.CAPACITY (CAPACITY),
		.LEVELS   (LEVELS),
		.W        (SW)
	) u_tables (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_lvl  (wr_lvl),
		.wr_pos  (wr_pos),
		.wr_min  (wr_min),
		.wr_max  (wr_max),
		.rd_en   (rd_en),
		.rd0_lvl (rd0_lvl),
		.rd0_pos (rd0_pos),
		.rd1_lvl (rd1_lvl),
		.rd1_pos (rd1_pos),
		.rd0_min (rd0_min),
		.rd0_max (rd0_max),
		.rd1_min (rd1_min),
		.rd1_max (rd1_max)
	);

	srmm_cmp #(
		.W (SW)
	) u_cmp (
		.a_min   (rd0_min),
		.b_min   (rd1_min),
		.a_max   (rd0_max),
		.b_max   (rd1_max),
		.res_min (cmp_min),
		.res_max (cmp_max)
	);

	assign in_xfer   = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	// Load decode: a load after a complete set restarts at position zero.
	assign eff_count = table_ready_q ? '0 : count_q;
	assign ovf       = 32'(eff_count) >= 32'(CAPACITY);

	// Query decode: range check, length, level and the start of the second window.
	assign bad_query = !table_ready_q || (lo_q > hi_q) || (32'(hi_q) >= 32'(count_q));
	assign len       = NW'({1'b0, hi_q} - {1'b0, lo_q} + NW'(1));
	assign k_raw     = srmm_pkg::floor_log2(len);
	assign k_lim     = (32'(k_raw) >= 32'(LEVELS)) ? KW'(LEVELS - 1) : KW'(k_raw);
	assign j2        = NW'({1'b0, hi_q} + NW'(1) - (NW'(1) << k_q));

	// Build loop conditions: level fits the set, and window at idx fits the set.
	assign lvl_ok = (32'(lvl_q) < 32'(LEVELS)) && ((32'd1 << lvl_q) <= 32'(count_q));
	assign idx_ok = (32'(idx_q) + (32'd1 << lvl_q)) <= 32'(count_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		emit        = 1'b0;
		emit_status = srmm_pkg::STATUS_BAD;
		load_commit = 1'b0;
		k_load      = 1'b0;
		build_start = 1'b0;
		lvl_inc     = 1'b0;
		idx_clr     = 1'b0;
		idx_inc     = 1'b0;
		set_ready   = 1'b0;
		wr_en       = 1'b0;
		wr_lvl      = '0;
		wr_pos      = AW'(eff_count);
		wr_min      = value_q;
		wr_max      = value_q;
		rd_en       = 1'b0;
		rd0_lvl     = k_q;
		rd0_pos     = AW'(lo_q);
		rd1_lvl     = k_q;
		rd1_pos     = AW'(j2);
		case (state_q)
			srmm_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (in_xfer) begin
					state_d = srmm_pkg::ST_EXEC;
				end
			end
			srmm_pkg::ST_EXEC: begin
				if (kind_q == srmm_pkg::KIND_LOAD) begin
					if (slot_free) begin
						emit        = 1'b1;
						emit_status = ovf ? srmm_pkg::STATUS_OVERFLOW : srmm_pkg::STATUS_LOADED;
						wr_en       = !ovf;
						load_commit = 1'b1;
						build_start = last_q;
						state_d     = last_q ? srmm_pkg::ST_B_CHK : srmm_pkg::ST_IDLE;
					end
				end else if (bad_query) begin
					if (slot_free) begin
						emit        = 1'b1;
						emit_status = srmm_pkg::STATUS_BAD;
						state_d     = srmm_pkg::ST_IDLE;
					end
				end else begin
					k_load  = 1'b1;
					state_d = srmm_pkg::ST_Q_RD;
				end
			end
			srmm_pkg::ST_Q_RD: begin
				rd_en   = 1'b1;
				state_d = srmm_pkg::ST_Q_CMP;
			end
			srmm_pkg::ST_Q_CMP: begin
				if (slot_free) begin
					emit        = 1'b1;
					emit_status = srmm_pkg::STATUS_OK;
					state_d     = srmm_pkg::ST_IDLE;
				end
			end
			srmm_pkg::ST_B_CHK: begin
				if (lvl_ok) begin
					idx_clr = 1'b1;
					state_d = srmm_pkg::ST_B_RD;
				end else begin
					set_ready = 1'b1;
					state_d   = srmm_pkg::ST_IDLE;
				end
			end
			srmm_pkg::ST_B_RD: begin
				rd0_lvl = KW'(lvl_q - LW'(1));
				rd0_pos = idx_q;
				rd1_lvl = KW'(lvl_q - LW'(1));
				rd1_pos = AW'(32'(idx_q) + (32'd1 << (lvl_q - LW'(1))));
				if (idx_ok) begin
					rd_en   = 1'b1;
					state_d = srmm_pkg::ST_B_WR;
				end else begin
					lvl_inc = 1'b1;
					state_d = srmm_pkg::ST_B_CHK;
				end
			end
			srmm_pkg::ST_B_WR: begin
				wr_en   = 1'b1;
				wr_lvl  = KW'(lvl_q);
				wr_pos  = idx_q;
				wr_min  = cmp_min;
				wr_max  = cmp_max;
				idx_inc = 1'b1;
				state_d = srmm_pkg::ST_B_RD;
			end
			default: begin
				state_d = srmm_pkg::ST_IDLE;
			end
		endcase
	end

	// Item register, loaded on each input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= req.kind;
			value_q <= req.value[SW-1:0];
			last_q  <= req.last_load;
			lo_q    <= req.range_low;
			hi_q    <= req.range_high;
		end
	end

	// Loaded count and table ready flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			table_ready_q <= 1'b0;
		end else if (load_commit) begin
			count_q       <= ovf ? eff_count : CW'(eff_count + CW'(1));
			table_ready_q <= 1'b0;
		end else if (set_ready) begin
			table_ready_q <= 1'b1;
		end
	end

	// Build level and position counters, query level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			idx_q <= '0;
			k_q   <= '0;
		end else begin
			if (build_start) begin
				lvl_q <= LW'(1);
			end else if (lvl_inc) begin
				lvl_q <= LW'(lvl_q + LW'(1));
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= AW'(idx_q + AW'(1));
			end
			if (k_load) begin
				k_q <= k_lim;
			end
		end
	end

	// Result register: filled when a result is due, emptied by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			if (emit_status == srmm_pkg::STATUS_OK) begin
				range_min_q <= VW'($signed(cmp_min));
				range_max_q <= VW'($signed(cmp_max));
			end else begin
				range_min_q <= '0;
				range_max_q <= '0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.range_min = range_min_q;
	assign rsp.range_max = range_max_q;
	assign rsp.status    = status_q;

`ifndef NO_ASSERTIONS
	// The loaded count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(CAPACITY))
		else $error("loaded count exceeds capacity");

	// Build writes never land on the loaded values at level zero.
	a_build_level: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == srmm_pkg::ST_B_WR) |-> (wr_lvl != '0))
		else $error("build write targets level zero");

	// A successful query answer only leaves while a complete set is held.
	a_ok_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_status == srmm_pkg::STATUS_OK) |-> table_ready_q)
		else $error("query answered without a complete set");

	// The ready flag is raised only at the end of a build.
	a_ready_after_build: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(table_ready_q) |-> $past(state_q == srmm_pkg::ST_B_CHK))
		else $error("table ready raised outside the build");

	// No input transfer is taken while a build is running.
	a_no_xfer_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srmm_pkg::ST_B_RD || state_q == srmm_pkg::ST_B_WR) |-> !in_xfer)
		else $error("input transfer during table build");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_sparse_table_range_min_max.sv =====
// Self-checking testbench for the sparse-table range min/max engine. It drives loads and
// queries with random idling on both channels and checks every result against a predictor.
// Depends on srmm_pkg, srmm_in_if, srmm_out_if and the sparse_table_range_min_max top level.
`default_nettype none

module tb_sparse_table_range_min_max;

	localparam int CAPACITY   = 1024;
	localparam int LEVELS     = 11;
	localparam int VALUE_BITS = 32;
	localparam int MAX_INDEX  = (1 << srmm_pkg::INDEX_W) - 1;
	localparam int RANDOM_ITEMS = 560;

	typedef struct {
		logic signed [srmm_pkg::VALUE_W-1:0] range_min;
		logic signed [srmm_pkg::VALUE_W-1:0] range_max;
		logic [srmm_pkg::STATUS_W-1:0]       status;
	} range_result_t;

	logic clk;
	logic arst_n;

	srmm_in_if  req_ch ();
	srmm_out_if rsp_ch ();

	sparse_table_range_min_max #(
		.CAPACITY   (CAPACITY),
		.LEVELS     (LEVELS),
		.VALUE_BITS (VALUE_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the engine: the values of the current set and its state.
	logic signed [srmm_pkg::VALUE_W-1:0] held_values [CAPACITY];
	int                                  held_count;
	bit                                  set_done;

	range_result_t pending_results [$];
	int            fail_count;
	bit            idle_on;
	int            random_sent;

	// Clock with a 12 unit period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the result of one accepted item and advances the shadow state.
	function automatic range_result_t predict_range_item(input logic kind,
			input logic signed [srmm_pkg::VALUE_W-1:0] value, input logic last,
			input logic [srmm_pkg::INDEX_W-1:0] lo, input logic [srmm_pkg::INDEX_W-1:0] hi);
		range_result_t res;
		res.range_min = '0;
		res.range_max = '0;
		res.status    = srmm_pkg::STATUS_BAD;
		if (kind == srmm_pkg::KIND_LOAD) begin
			// A load after a finished set opens a new one at position zero.
			if (set_done) begin
				set_done   = 1'b0;
				held_count = 0;
			end
			if (held_count >= CAPACITY) begin
				res.status = srmm_pkg::STATUS_OVERFLOW;
			end else begin
				held_values[held_count] = value;
				held_count++;
				res.status = srmm_pkg::STATUS_LOADED;
			end
			if (last) begin
				set_done = 1'b1;
			end
		end else if (set_done && lo <= hi && int'(hi) < held_count) begin
			// The expected min and max come from a direct scan of every value in lo..hi.
			res.range_min = held_values[lo];
			res.range_max = held_values[lo];
			for (int i = lo; i <= hi; i++) begin
				if (held_values[i] < res.range_min) begin
					res.range_min = held_values[i];
				end
				if (held_values[i] > res.range_max) begin
					res.range_max = held_values[i];
				end
			end
			res.status = srmm_pkg::STATUS_OK;
		end
		return res;
	endfunction

	function automatic logic signed [srmm_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: begin
				return 32'sh7fffffff;
			end
			1: begin
				return 32'sh80000000;
			end
			2: begin
				return '0;
			end
			3: begin
				return -1;
			end
			4, 5: begin
				return int'($urandom_range(0, 64)) - 32;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endtask

	// Sends one item; called at a rising edge and returns at the edge of its transfer.
	task automatic send_item(input logic kind, input logic signed [srmm_pkg::VALUE_W-1:0] value,
			input logic last, input logic [srmm_pkg::INDEX_W-1:0] lo,
			input logic [srmm_pkg::INDEX_W-1:0] hi);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= kind;
		req_ch.value      <= value;
		req_ch.last_load  <= last;
		req_ch.range_low  <= lo;
		req_ch.range_high <= hi;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.push_back(predict_range_item(kind, value, last, lo, hi));
	endtask

	// Loads carry random index fields and queries random value fields; both are ignored.
	task automatic load_value(input logic signed [srmm_pkg::VALUE_W-1:0] value, input logic last);
		send_item(srmm_pkg::KIND_LOAD, value, last, srmm_pkg::INDEX_W'($urandom),
			srmm_pkg::INDEX_W'($urandom));
	endtask

	task automatic query_range(input int lo, input int hi);
		send_item(srmm_pkg::KIND_QUERY, $urandom, 1'($urandom), srmm_pkg::INDEX_W'(lo),
			srmm_pkg::INDEX_W'(hi));
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Result checker: every transfer on rsp is matched against the oldest expectation.
	always @(posedge clk) begin
		range_result_t exp_res;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result min=%0d max=%0d status=%0d",
					rsp_ch.range_min, rsp_ch.range_max, rsp_ch.status));
			end else begin
				exp_res = pending_results.pop_front();
				if (rsp_ch.status !== exp_res.status || rsp_ch.range_min !== exp_res.range_min
						|| rsp_ch.range_max !== exp_res.range_max) begin
					note_failure($sformatf(
						"expected min=%0d max=%0d status=%0d, got min=%0d max=%0d status=%0d",
						exp_res.range_min, exp_res.range_max, exp_res.status,
						rsp_ch.range_min, rsp_ch.range_max, rsp_ch.status));
				end
			end
		end
	end

	// Result side: ready drops in random stall bursts while idling is enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Queries with no finished set, including the widest indexes and an inverted pair.
	task automatic test_query_before_set();
		query_range(0, 0);
		query_range(MAX_INDEX, MAX_INDEX);
		query_range(5, 2);
	endtask

	// A set of one value: the only valid range is 0..0.
	task automatic test_single_value();
		load_value(32'sh80000000, 1'b1);
		query_range(0, 0);
		query_range(0, 1);
	endtask

	// Extreme values, a query while a set is still loading, and out-of-range requests.
	task automatic test_extreme_values();
		load_value(32'sh7fffffff, 1'b0);
		load_value(32'sh80000000, 1'b0);
		load_value('0, 1'b0);
		query_range(0, 1);
		load_value(-1, 1'b0);
		load_value(1, 1'b1);
		query_range(0, 4);
		query_range(0, 0);
		query_range(1, 1);
		query_range(3, 4);
		query_range(2, 3);
		query_range(4, 3);
		query_range(0, 5);
		query_range(0, MAX_INDEX);
	endtask

	// Fills the set to capacity, then overflows it; the flagged overflow still ends the set.
	task automatic test_capacity_overflow();
		int lo;
		for (int i = 0; i < CAPACITY; i++) begin
			load_value(rand_value(), 1'b0);
		end
		load_value(rand_value(), 1'b0);
		load_value(32'sh7fffffff, 1'b0);
		load_value(32'sh80000000, 1'b1);
		// Hold the sender back until every load has been answered.
		wait_results_drained();
		query_range(0, MAX_INDEX);
		query_range(MAX_INDEX, MAX_INDEX);
		query_range(512, MAX_INDEX);
		query_range(0, 511);
		for (int i = 0; i < 12; i++) begin
			lo = $urandom_range(0, MAX_INDEX);
			query_range(lo, $urandom_range(lo, MAX_INDEX));
		end
	endtask

	// Random sets of random size, each followed by a burst of mostly valid queries.
	task automatic test_random_sets();
		int n;
		int n_queries;
		int lo;
		int hi;
		int k;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent % 150 < 20) begin
				idle_on = ($urandom_range(0, 2) != 0);
			end
			if ($urandom_range(0, 24) == 0) begin
				n = $urandom_range(100, 200);
			end else begin
				n = $urandom_range(1, 40);
			end
			for (int i = 0; i < n; i++) begin
				// Now and then a query lands in the middle of loading.
				if ($urandom_range(0, 29) == 0) begin
					query_range($urandom_range(0, n - 1), $urandom_range(0, MAX_INDEX));
					random_sent++;
				end
				load_value(rand_value(), i == n - 1);
				random_sent++;
			end
			n_queries = $urandom_range(5, 30);
			for (int q = 0; q < n_queries; q++) begin
				lo = $urandom_range(0, n - 1);
				case ($urandom_range(0, 9))
					0, 1: begin
						query_range($urandom_range(0, MAX_INDEX), $urandom_range(0, MAX_INDEX));
					end
					2: begin
						query_range(lo, (n < CAPACITY) ? n : lo - 1);
					end
					3, 4: begin
						k = $urandom_range(0, LEVELS - 1);
						hi = lo + (1 << k) - 1;
						query_range(lo, (hi > n - 1) ? n - 1 : hi);
					end
					default: begin
						query_range(lo, $urandom_range(lo, n - 1));
					end
				endcase
				random_sent++;
			end
		end
	endtask

	// Closing stretch with both channels running flat out.
	task automatic test_no_idle_stretch();
		int lo;
		idle_on = 1'b0;
		for (int i = 0; i < 64; i++) begin
			load_value(rand_value(), i == 63);
		end
		for (int q = 0; q < 64; q++) begin
			lo = $urandom_range(0, 63);
			query_range(lo, $urandom_range(lo, 63));
		end
	endtask

	// Run limit, far beyond the slowest correct run.
	initial begin
		#(12 * 1000000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = srmm_pkg::KIND_LOAD;
		req_ch.value = '0;
		req_ch.last_load = 1'b0;
		req_ch.range_low = '0;
		req_ch.range_high = '0;
		held_count = 0;
		set_done = 1'b0;
		fail_count = 0;
		random_sent = 0;
		idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_query_before_set();
		test_single_value();
		test_extreme_values();
		test_capacity_overflow();
		test_random_sets();
		test_no_idle_stretch();

		wait_results_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/srmm_pkg.sv
src/srmm_in_if.sv
src/srmm_out_if.sv
src/srmm_tables.sv
src/srmm_cmp.sv
src/sparse_table_range_min_max.sv
bench/tb_sparse_table_range_min_max.sv
